### sv/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types, field widths, register indexes and the code tables of the
// 3x3 local binary pattern stream.
// ----------------------------------------------------------------------------
package lbp_pkg;

    // Field widths
    localparam int PIXEL_W     = 8;
    localparam int CODE_W      = 8;
    localparam int MODE_W      = 2;
    localparam int WIDTH_W     = 12;
    localparam int HEIGHT_W    = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    // Pattern modes; the unused code behaves as plain
    localparam logic [MODE_W-1:0] MODE_PLAIN   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ROT_MIN = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNIFORM = 2'd2;

    // Reset values of the size registers
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

    // Smallest legal frame dimension
    localparam int MIN_DIM = 3;

    typedef logic [CODE_W-1:0] code_tab_t [256];

    // 3x3 neighbourhood handed to the code unit
    typedef struct packed {
        logic [PIXEL_W-1:0] top_left;
        logic [PIXEL_W-1:0] top;
        logic [PIXEL_W-1:0] top_right;
        logic [PIXEL_W-1:0] right;
        logic [PIXEL_W-1:0] bottom_right;
        logic [PIXEL_W-1:0] bottom;
        logic [PIXEL_W-1:0] bottom_left;
        logic [PIXEL_W-1:0] left;
        logic [PIXEL_W-1:0] centre;
    } lbp_nbhd_t;

    // Minimum over the eight circular rotations of each code
    function automatic code_tab_t build_rot_min_tab();
        code_tab_t   tab;
        logic [7:0]  c;
        logic [7:0]  v;
        logic [7:0]  best;
        for (int code = 0; code < 256; code++)
        begin
            c    = 8'(code);
            best = c;
            for (int r = 1; r < 8; r++)
            begin
                v = (c << r) | (c >> (8 - r));
                if (v < best)
                    best = v;
            end
            tab[code] = best;
        end
        return tab;
    endfunction

    // Uniform label: 1..58 in code order for at most two circular transitions
    function automatic code_tab_t build_uniform_tab();
        code_tab_t   tab;
        logic [7:0]  c;
        int          trans;
        int          label;
        label = 1;
        for (int code = 0; code < 256; code++)
        begin
            c     = 8'(code);
            trans = 0;
            for (int r = 0; r < 8; r++)
            begin
                if (c[r] != c[(r + 1) % 8])
                    trans++;
            end
            if (trans <= 2)
            begin
                tab[code] = 8'(label);
                label++;
            end
            else
            begin
                tab[code] = '0;
            end
        end
        return tab;
    endfunction

    localparam code_tab_t ROT_MIN_TAB = build_rot_min_tab();
    localparam code_tab_t UNIFORM_TAB = build_uniform_tab();

endpackage

### sv/lbp_if.sv
// ----------------------------------------------------------------------------
// lbp_if
// Valid/ready stream interfaces: pixels in, pattern codes out.
// ----------------------------------------------------------------------------
interface lbp_pixel_if
    import lbp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;
    logic               frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface lbp_code_if
    import lbp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] pattern_code;
    logic              row_end;
    logic              frame_end;

    modport source (output valid, output pattern_code, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input pattern_code, input row_end, input frame_end,
                    output ready);
endinterface

### sv/lbp_3x3_code_stream.sv
// ----------------------------------------------------------------------------
// lbp_3x3_code_stream
// 3x3 local binary pattern over a raster pixel stream, with plain,
// rotation-minimum and uniform-label outputs.
// ----------------------------------------------------------------------------
//  Channel       Dir  Handshake            Payload
//  pixel_stream  in   valid/ready          pixel[7:0], frame_start
//  code_stream   out  valid/ready          pattern_code[7:0], row_end, frame_end
//  cfg           in   cfg_we (no ready)    cfg_index[1:0], cfg_data[12:0]
//
//  One pixel per clock sustained while the result register is not stalled; a code
//  leaves through the line store read register, then the result register.
//  Border pixels produce no code. Reset clears counters, window and the
//  line-store fill count; unwritten columns read as zero.
//  A stalled result register holds the pipeline; pixel_stream.ready falls
//  only while the result register is full and not being taken.
// ----------------------------------------------------------------------------
module lbp_3x3_code_stream
    import lbp_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    lbp_pixel_if.sink               pixel_stream,
    lbp_code_if.source              code_stream,
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = (CW + 1 > WIDTH_W)  ? CW + 1 : WIDTH_W;
    localparam int HW = (RW + 1 > HEIGHT_W) ? RW + 1 : HEIGHT_W;

    // Configuration registers
    logic [MODE_W-1:0]   pattern_mode_reg;
    logic [WIDTH_W-1:0]  image_width_reg;
    logic [HEIGHT_W-1:0] image_height_reg;

    // Raster counters
    logic [CW-1:0] col_cnt_reg;
    logic [RW-1:0] row_cnt_reg;

    // Stage 1: item waiting on line store data
    logic               s1_valid_reg;
    logic [PIXEL_W-1:0] s1_pixel_reg;
    logic [CW-1:0]      s1_col_reg;
    logic               s1_result_reg;
    logic               s1_row_end_reg;
    logic               s1_frame_end_reg;

    // Two previous window columns: 0..2 older, 3..5 newer (top, mid, bottom)
    logic [PIXEL_W-1:0] win_reg [6];

    // Result register
    logic              out_valid_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic              out_row_end_reg;
    logic              out_frame_end_reg;

    logic                 accept;
    logic                 advance;
    logic [WW-1:0]        width_ext;
    logic [WW-1:0]        width_eff;
    logic [HW-1:0]        height_ext;
    logic [HW-1:0]        height_eff;
    logic [CW-1:0]        cur_col;
    logic [RW-1:0]        cur_row;
    logic                 last_col;
    logic                 last_row;
    logic                 has_result;
    logic [2*PIXEL_W-1:0] line_rd;
    logic [PIXEL_W-1:0]   top_px;
    logic [PIXEL_W-1:0]   mid_px;
    lbp_nbhd_t            nbhd;
    logic [CODE_W-1:0]    code;

    // Handshake
    assign advance            = s1_valid_reg && (!out_valid_reg || code_stream.ready);
    assign pixel_stream.ready = !s1_valid_reg || advance;
    assign accept             = pixel_stream.valid && pixel_stream.ready;

    // Clamp frame size to 3..MAX
    assign width_ext  = WW'(image_width_reg);
    assign height_ext = HW'(image_height_reg);
    always_comb
    begin
        if (width_ext < WW'(MIN_DIM))
            width_eff = WW'(MIN_DIM);
        else if (width_ext > WW'(MAX_WIDTH))
            width_eff = WW'(MAX_WIDTH);
        else
            width_eff = width_ext;

        if (height_ext < HW'(MIN_DIM))
            height_eff = HW'(MIN_DIM);
        else if (height_ext > HW'(MAX_HEIGHT))
            height_eff = HW'(MAX_HEIGHT);
        else
            height_eff = height_ext;
    end

    // Position of the incoming pixel; frame_start forces row 0, column 0
    assign cur_col    = pixel_stream.frame_start ? '0 : col_cnt_reg;
    assign cur_row    = pixel_stream.frame_start ? '0 : row_cnt_reg;
    assign last_col   = WW'(cur_col) >= (width_eff - WW'(1));
    assign last_row   = HW'(cur_row) >= (height_eff - HW'(1));
    assign has_result = (cur_row >= RW'(2)) && (cur_col >= CW'(2));

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_mode_reg <= MODE_PLAIN;
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PATTERN_MODE: pattern_mode_reg <= cfg_data[MODE_W-1:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Raster counters and stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg      <= '0;
            row_cnt_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            s1_result_reg    <= 1'b0;
            s1_row_end_reg   <= 1'b0;
            s1_frame_end_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg     <= 1'b1;
            s1_result_reg    <= has_result;
            s1_row_end_reg   <= last_col;
            s1_frame_end_reg <= last_col && last_row;
            if (last_col)
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= last_row ? '0 : cur_row + RW'(1);
            end
            else
            begin
                col_cnt_reg <= cur_col + CW'(1);
                row_cnt_reg <= cur_row;
            end
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel_stream.pixel;
            s1_col_reg   <= cur_col;
        end
    end

    // Line store: upper row in the high byte, middle row in the low byte
    lbp_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (cur_col),
        .rd_data (line_rd),
        .wr_en   (advance),
        .wr_addr (s1_col_reg),
        .wr_data ({mid_px, s1_pixel_reg})
    );

    assign top_px = line_rd[2*PIXEL_W-1:PIXEL_W];
    assign mid_px = line_rd[PIXEL_W-1:0];

    // Neighbourhood around the centre at the previous column, middle row
    assign nbhd.top_left     = win_reg[0];
    assign nbhd.top          = win_reg[3];
    assign nbhd.top_right    = top_px;
    assign nbhd.right        = mid_px;
    assign nbhd.bottom_right = s1_pixel_reg;
    assign nbhd.bottom       = win_reg[5];
    assign nbhd.bottom_left  = win_reg[2];
    assign nbhd.left         = win_reg[1];
    assign nbhd.centre       = win_reg[4];

    lbp_code_unit u_code_unit (
        .nbhd (nbhd),
        .mode (pattern_mode_reg),
        .code (code)
    );

    // Window shift as each item leaves stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (advance)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_px;
            win_reg[4] <= mid_px;
            win_reg[5] <= s1_pixel_reg;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_result_reg;
        else if (code_stream.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_code_reg      <= code;
            out_row_end_reg   <= s1_row_end_reg;
            out_frame_end_reg <= s1_frame_end_reg;
        end
    end

    assign code_stream.valid        = out_valid_reg;
    assign code_stream.pattern_code = out_code_reg;
    assign code_stream.row_end      = out_row_end_reg;
    assign code_stream.frame_end    = out_frame_end_reg;

endmodule

### sv/lbp_line_store.sv
// ----------------------------------------------------------------------------
// lbp_line_store
// Two-row line store held as one memory word per column {upper, middle}.
// Registered read, write-to-read bypass and a fill count so that columns
// never written since reset read as zero.
// ----------------------------------------------------------------------------
module lbp_line_store
    import lbp_pkg::*;
#(
    parameter int DEPTH = 2048
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [2*PIXEL_W-1:0]       rd_data,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [2*PIXEL_W-1:0]       wr_data
);
    localparam int AW = $clog2(DEPTH);

    logic [2*PIXEL_W-1:0] mem [DEPTH];
    logic [2*PIXEL_W-1:0] raw_reg;
    logic [2*PIXEL_W-1:0] byp_data_reg;
    logic                 byp_reg;
    logic                 blank_reg;
    logic [AW:0]          fill_reg;
    logic                 rd_blank;

    // Columns at or above the fill count have never been written
    assign rd_blank = ({1'b0, rd_addr} >= fill_reg);

    // Memory array
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            raw_reg      <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    // Read qualifiers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg   <= 1'b0;
            blank_reg <= 1'b1;
            fill_reg  <= '0;
        end
        else if (rd_en)
        begin
            byp_reg   <= wr_en && (wr_addr == rd_addr);
            blank_reg <= rd_blank;
            if (rd_blank)
                fill_reg <= {1'b0, rd_addr} + (AW+1)'(1);
        end
    end

    // Bypass wins over the blank mark
    assign rd_data = byp_reg   ? byp_data_reg :
                     blank_reg ? '0           : raw_reg;

endmodule

### sv/lbp_code_unit.sv
// ----------------------------------------------------------------------------
// lbp_code_unit
// Eight neighbour compares against the centre and the mode table lookup.
// ----------------------------------------------------------------------------
module lbp_code_unit
    import lbp_pkg::*;
(
    input  lbp_nbhd_t          nbhd,
    input  logic [MODE_W-1:0]  mode,
    output logic [CODE_W-1:0]  code
);
    logic [CODE_W-1:0] raw_code;

    // Bit 7 top-left, clockwise down to bit 0 on the left
    assign raw_code = {
        nbhd.top_left     >= nbhd.centre,
        nbhd.top          >= nbhd.centre,
        nbhd.top_right    >= nbhd.centre,
        nbhd.right        >= nbhd.centre,
        nbhd.bottom_right >= nbhd.centre,
        nbhd.bottom       >= nbhd.centre,
        nbhd.bottom_left  >= nbhd.centre,
        nbhd.left         >= nbhd.centre
    };

    always_comb
    begin
        case (mode)
            MODE_ROT_MIN: code = ROT_MIN_TAB[raw_code];
            MODE_UNIFORM: code = UNIFORM_TAB[raw_code];
            MODE_PLAIN:   code = raw_code;
            default:      code = raw_code;
        endcase
    end

endmodule
